/* hdl/tiffp_pkg.sv */
// Package for the TIFF header and first-IFD parser.
// Holds the stream item types, result codes, tag numbers and value maps.
// No dependencies.
package tiffp_pkg;

    localparam int OFFSET_BITS_DEF = 32;
    localparam int POS_BITS        = 32;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_SIG   = 2'd1;
    localparam logic [1:0] ST_TRUNCATED = 2'd2;
    localparam logic [1:0] ST_BEHIND    = 2'd3;

    // Byte order marks
    localparam logic [7:0] BOM_INTEL    = 8'h49;
    localparam logic [7:0] BOM_MOTOROLA = 8'h4D;

    // Tags of interest
    localparam logic [15:0] TAG_WIDTH       = 16'd256;
    localparam logic [15:0] TAG_HEIGHT      = 16'd257;
    localparam logic [15:0] TAG_BPS         = 16'd258;
    localparam logic [15:0] TAG_COMPRESSION = 16'd259;
    localparam logic [15:0] TAG_PHOTOMETRIC = 16'd262;
    localparam logic [15:0] TAG_SPP         = 16'd277;

    localparam logic [15:0] TYPE_SHORT    = 16'd3;
    localparam logic [31:0] COMP_PACKBITS = 32'd32773;

    localparam logic [2:0] COMP_INVALID  = 3'd7;
    localparam logic [3:0] COLOR_CMYK_IN = 4'd7;
    localparam logic [3:0] COLOR_INVALID = 4'd8;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic        big_endian;
        logic [31:0] image_width;
        logic [31:0] image_height;
        logic [15:0] bits_per_sample;
        logic [2:0]  compression_code;
        logic [3:0]  color_code;
        logic [15:0] samples_per_pixel;
        logic [15:0] entry_count;
        logic [31:0] next_ifd_offset;
    } t_out_item;

    // Result of one parser step, handed from the core to the output stage
    typedef struct packed {
        logic      valid;
        t_out_item item;
    } t_core_res;

    // Map the compression tag value to its code
    function automatic logic [2:0] map_compression(input logic [31:0] v);
        logic [2:0] code;
        code = COMP_INVALID;
        if (v >= 32'd1 && v <= 32'd6) begin
            code = 3'(v - 32'd1);
        end else if (v == COMP_PACKBITS) begin
            code = 3'd6;
        end
        return code;
    endfunction

    // Map the photometric tag value to its code
    function automatic logic [3:0] map_color(input logic [31:0] v);
        logic [3:0] code;
        code = COLOR_INVALID;
        if (v <= 32'd6) begin
            code = 4'(v);
        end else if (v == 32'd8) begin
            code = COLOR_CMYK_IN;
        end
        return code;
    endfunction

endpackage

/* hdl/tiffp_stream_if.sv */
// Valid/ready stream interface for the TIFF parser channels.
// The payload type is given by the instantiating level.
interface tiffp_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* hdl/tiffp_parse_core.sv */
// Byte-serial TIFF header / IFD parser state and next-state logic.
// Depends on tiffp_pkg. State advances on each input transfer.
module tiffp_parse_core
    import tiffp_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_advance,
    input  t_in_item  i_item,
    output t_core_res o_res
);

    typedef enum logic [7:0] {
        PH_SIG     = 8'b0000_0001,
        PH_VERSION = 8'b0000_0010,
        PH_OFFSET  = 8'b0000_0100,
        PH_SKIP    = 8'b0000_1000,
        PH_COUNT   = 8'b0001_0000,
        PH_ENTRY   = 8'b0010_0000,
        PH_NEXT    = 8'b0100_0000,
        PH_DONE    = 8'b1000_0000
    } t_phase;

    t_phase                 r_phase, n_phase;
    logic [POS_BITS-1:0]    r_pos, n_pos;
    logic                   r_big, n_big;
    logic [31:0]            r_fb, n_fb;
    logic [3:0]             r_idx, n_idx;
    logic [OFFSET_BITS-1:0] r_tgt, n_tgt;
    logic [15:0]            r_left, n_left;
    logic [15:0]            r_tag, n_tag;
    logic [15:0]            r_typ, n_typ;
    logic [31:0]            r_cnt, n_cnt;
    logic [31:0]            r_width, n_width;
    logic [31:0]            r_height, n_height;
    logic [15:0]            r_bps, n_bps;
    logic [15:0]            r_spp, n_spp;
    logic [2:0]             r_comp, n_comp;
    logic [3:0]             r_color, n_color;
    logic [15:0]            r_ecount, n_ecount;

    // Merge one byte into the field word in the file's byte order
    function automatic logic [31:0] put_byte(input logic [31:0] fb, input logic [7:0] b,
                                             input logic [1:0] k, input logic big);
        logic [31:0] res;
        if (big) begin
            res = {fb[23:0], b};
        end else begin
            res = fb | ({24'd0, b} << {k, 3'b000});
        end
        return res;
    endfunction

    t_phase      ph;
    logic [3:0]  k;
    logic [31:0] fb;
    logic [31:0] pb;
    logic [1:0]  lk;
    logic [31:0] val;
    logic [15:0] left_dec;
    logic        emit;
    logic [1:0]  emit_status;
    logic [31:0] emit_next;
    logic [OFFSET_BITS-1:0] tgt_new;

    always_comb begin
        n_phase  = r_phase;
        n_pos    = (r_pos == '1) ? r_pos : r_pos + 1'b1;
        n_big    = r_big;
        n_fb     = r_fb;
        n_idx    = r_idx;
        n_tgt    = r_tgt;
        n_left   = r_left;
        n_tag    = r_tag;
        n_typ    = r_typ;
        n_cnt    = r_cnt;
        n_width  = r_width;
        n_height = r_height;
        n_bps    = r_bps;
        n_spp    = r_spp;
        n_comp   = r_comp;
        n_color  = r_color;
        n_ecount = r_ecount;
        emit        = 1'b0;
        emit_status = ST_OK;
        emit_next   = 32'd0;
        ph  = r_phase;
        k   = r_idx;
        fb  = r_fb;
        lk  = r_idx[1:0];
        val = 32'd0;
        left_dec = 16'(r_left - 16'd1);
        tgt_new  = '0;

        // Leave the skip run when the cursor reaches the IFD offset
        if (r_phase == PH_SKIP && r_pos == POS_BITS'(r_tgt)) begin
            ph    = PH_COUNT;
            fb    = 32'd0;
            k     = 4'd0;
            n_phase = PH_COUNT;
            n_fb    = 32'd0;
            n_idx   = 4'd0;
        end

        // Entry bytes restart their local index at each sub-field
        if (ph == PH_ENTRY && (k == 4'd2 || k == 4'd3)) begin
            lk = {1'b0, k[0]};
        end else begin
            lk = k[1:0];
        end
        pb = put_byte(fb, i_item.data_byte, lk, r_big);

        unique case (ph)
            PH_SIG: begin
                if (k == 4'd0) begin
                    n_fb  = {24'd0, i_item.data_byte};
                    n_idx = 4'd1;
                end else if (fb == {24'd0, BOM_MOTOROLA} && i_item.data_byte == BOM_MOTOROLA) begin
                    n_big   = 1'b1;
                    n_phase = PH_VERSION;
                    n_fb    = 32'd0;
                    n_idx   = 4'd0;
                end else if (fb == {24'd0, BOM_INTEL} && i_item.data_byte == BOM_INTEL) begin
                    n_big   = 1'b0;
                    n_phase = PH_VERSION;
                    n_fb    = 32'd0;
                    n_idx   = 4'd0;
                end else begin
                    n_big       = 1'b0;
                    emit        = 1'b1;
                    emit_status = ST_BAD_SIG;
                end
            end
            PH_VERSION: begin
                if (k == 4'd0) begin
                    n_idx = 4'd1;
                end else begin
                    n_phase = PH_OFFSET;
                    n_fb    = 32'd0;
                    n_idx   = 4'd0;
                end
            end
            PH_OFFSET: begin
                if (k < 4'd3) begin
                    n_fb  = pb;
                    n_idx = k + 4'd1;
                end else begin
                    tgt_new = pb[OFFSET_BITS-1:0];
                    n_tgt   = tgt_new;
                    n_fb    = 32'd0;
                    n_idx   = 4'd0;
                    if (tgt_new < OFFSET_BITS'(8)) begin
                        emit        = 1'b1;
                        emit_status = ST_BEHIND;
                    end else begin
                        n_phase = PH_SKIP;
                    end
                end
            end
            PH_COUNT: begin
                if (k == 4'd0) begin
                    n_fb  = pb;
                    n_idx = 4'd1;
                end else begin
                    n_left   = pb[15:0];
                    n_ecount = pb[15:0];
                    n_fb     = 32'd0;
                    n_idx    = 4'd0;
                    n_phase  = (pb[15:0] == 16'd0) ? PH_NEXT : PH_ENTRY;
                end
            end
            PH_ENTRY: begin
                n_idx = k + 4'd1;
                if (k == 4'd1) begin
                    n_tag = pb[15:0];
                    n_fb  = 32'd0;
                end else if (k == 4'd3) begin
                    n_typ = pb[15:0];
                    n_fb  = 32'd0;
                end else if (k == 4'd7) begin
                    n_cnt = pb;
                    n_fb  = 32'd0;
                end else if (k >= 4'd11) begin
                    // Pick the value from the first two bytes for SHORT
                    if (r_typ == TYPE_SHORT) begin
                        val = r_big ? {16'd0, pb[31:16]} : {16'd0, pb[15:0]};
                    end else begin
                        val = pb;
                    end
                    if (r_tag == TAG_WIDTH) begin
                        n_width = val;
                    end
                    if (r_tag == TAG_HEIGHT) begin
                        n_height = val;
                    end
                    if (r_tag == TAG_BPS) begin
                        n_bps = (r_cnt == 32'd1) ? val[15:0] : 16'd0;
                    end
                    if (r_tag == TAG_COMPRESSION) begin
                        n_comp = map_compression(val);
                    end
                    if (r_tag == TAG_PHOTOMETRIC) begin
                        n_color = map_color(val);
                    end
                    if (r_tag == TAG_SPP) begin
                        n_spp = val[15:0];
                    end
                    n_fb   = 32'd0;
                    n_idx  = 4'd0;
                    n_left = left_dec;
                    if (left_dec == 16'd0) begin
                        n_phase = PH_NEXT;
                    end
                end else begin
                    n_fb = pb;
                end
            end
            PH_NEXT: begin
                if (k < 4'd3) begin
                    n_fb  = pb;
                    n_idx = k + 4'd1;
                end else begin
                    emit        = 1'b1;
                    emit_status = ST_OK;
                    emit_next   = pb;
                end
            end
            PH_SKIP, PH_DONE: begin
            end
            default: begin
            end
        endcase

        if (emit) begin
            n_phase = PH_DONE;
        end

        // Flag a short file on its last byte
        if (i_item.last_byte && !emit && n_phase != PH_DONE) begin
            emit        = 1'b1;
            emit_status = ST_TRUNCATED;
        end

        // Build the result; error results carry only status and byte order
        o_res.valid                  = emit;
        o_res.item.status            = emit_status;
        o_res.item.big_endian        = n_big;
        o_res.item.image_width       = (emit_status == ST_OK) ? r_width  : 32'd0;
        o_res.item.image_height      = (emit_status == ST_OK) ? r_height : 32'd0;
        o_res.item.bits_per_sample   = (emit_status == ST_OK) ? r_bps    : 16'd0;
        o_res.item.compression_code  = (emit_status == ST_OK) ? r_comp   : 3'd0;
        o_res.item.color_code        = (emit_status == ST_OK) ? r_color  : 4'd0;
        o_res.item.samples_per_pixel = (emit_status == ST_OK) ? r_spp    : 16'd0;
        o_res.item.entry_count       = (emit_status == ST_OK) ? r_ecount : 16'd0;
        o_res.item.next_ifd_offset   = emit_next;
    end

    // Advance on each transfer; the last byte re-arms the parser
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_advance && i_item.last_byte)) begin
            r_phase  <= PH_SIG;
            r_pos    <= '0;
            r_big    <= 1'b0;
            r_fb     <= 32'd0;
            r_idx    <= 4'd0;
            r_tgt    <= '0;
            r_left   <= 16'd0;
            r_tag    <= 16'd0;
            r_typ    <= 16'd0;
            r_cnt    <= 32'd0;
            r_width  <= 32'd0;
            r_height <= 32'd0;
            r_bps    <= 16'd0;
            r_spp    <= 16'd0;
            r_comp   <= 3'd0;
            r_color  <= 4'd0;
            r_ecount <= 16'd0;
        end else if (i_advance) begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_big    <= n_big;
            r_fb     <= n_fb;
            r_idx    <= n_idx;
            r_tgt    <= n_tgt;
            r_left   <= n_left;
            r_tag    <= n_tag;
            r_typ    <= n_typ;
            r_cnt    <= n_cnt;
            r_width  <= n_width;
            r_height <= n_height;
            r_bps    <= n_bps;
            r_spp    <= n_spp;
            r_comp   <= n_comp;
            r_color  <= n_color;
            r_ecount <= n_ecount;
        end
    end

endmodule

/* hdl/tiff_ifd_header_parser.sv */
// TIFF header and first-IFD parser, one file byte per transfer.
// Throughput: one byte per cycle unless stalled; the parser core is combinational.
// The core's result for a byte is loaded into the output register on its transfer.
// The output register stalls input only while a result is held and not taken.
// Reset (synchronous, active low) re-arms the parser and empties the output register.
module tiff_ifd_header_parser
    import tiffp_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    tiffp_stream_if.sink          i_in,
    tiffp_stream_if.source        o_out
);

    t_core_res core_res;
    logic      in_xfer;
    logic      r_out_valid, n_out_valid;
    t_out_item r_out;

    // Accept a byte whenever the output register can take its result
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_xfer    = i_in.valid && i_in.ready;

    tiffp_parse_core #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (in_xfer),
        .i_item    (i_in.payload),
        .o_res     (core_res)
    );

    // Hold the result until taken, load a new one on each transfer that yields one
    always_comb begin
        if (in_xfer) begin
            n_out_valid = core_res.valid;
        end else begin
            n_out_valid = r_out_valid && !o_out.ready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer && core_res.valid) begin
            r_out <= core_res.item;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

endmodule

/* hdl/tiffp_checker.sv */
// Port-level checks for the TIFF parser, bound to the top level.
// Depends on tiffp_pkg.
module tiffp_checker
    import tiffp_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      i_in_ready,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_out_item i_out_item
);

    // Hold a result until it is taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // Error results carry no image summary
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_item.status != ST_OK |->
            i_out_item.image_width == 32'd0 && i_out_item.image_height == 32'd0 &&
            i_out_item.entry_count == 16'd0 && i_out_item.next_ifd_offset == 32'd0)
        else $error("error result with summary fields");

    // A bad signature reports the byte order as little-endian
    a_badsig_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_item.status == ST_BAD_SIG |-> !i_out_item.big_endian)
        else $error("bad signature with big-endian set");

    // Take input whenever no result is waiting
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output");

    // Leave reset with no result pending
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !i_out_valid && (i_in_ready || !i_in_valid))
        else $error("result pending after reset");

endmodule

bind tiff_ifd_header_parser tiffp_checker u_tiffp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_item  (o_out.payload)
);

/* verif/tb_tiff_ifd_header_parser.sv */
`timescale 1ns / 1ps
// Testbench for tiff_ifd_header_parser: feeds whole TIFF byte streams and checks the summaries.
// Depends on tiffp_pkg, tiffp_stream_if and the parser RTL.
module tb_tiff_ifd_header_parser;
    import tiffp_pkg::*;

    localparam int OFFSET_BITS   = OFFSET_BITS_DEF;
    localparam int ITEM_TARGET   = 1300;
    localparam int HOLD_CYCLES   = 300;
    localparam int WATCH_LIMIT   = 4000;
    localparam int DRAIN_CYCLES  = 8;
    localparam logic [15:0] TYPE_LONG = 16'd4;

    // Parser progress through one file
    typedef enum logic [3:0] {
        HDR_MARK, HDR_VERSION, HDR_OFFSET, SEEK_IFD,
        IFD_COUNT, IFD_ENTRY, IFD_NEXT, PARSE_DONE
    } t_scan_phase;

    // Shapes of generated files
    typedef enum int {
        FILE_GOOD, FILE_CUT, FILE_BAD_MARK, FILE_BEHIND,
        FILE_FAR, FILE_NOISE, FILE_LONG_COUNT
    } t_file_kind;

    // Tracks the parser state per accepted byte and holds the summaries still owed
    class t_summary_board;
        t_out_item   summary_q[$];
        int          errors;
        int          predicted;
        int          checked;
        int          ok_seen;
        t_scan_phase phase;
        logic [31:0] cursor;
        logic        motorola;
        logic [31:0] acc;
        int unsigned acc_idx;
        logic [31:0] ifd_start;
        logic [15:0] entries_todo;
        logic [15:0] cur_tag;
        logic [15:0] cur_type;
        logic [31:0] cur_count;
        logic [31:0] width;
        logic [31:0] height;
        logic [15:0] bps;
        logic [15:0] spp;
        logic [2:0]  comp;
        logic [3:0]  color;
        logic [15:0] n_entries;
        logic        summary_sent;

        function new();
            rearm();
        endfunction

        function void rearm();
            phase        = HDR_MARK;
            cursor       = '0;
            motorola     = 1'b0;
            acc          = '0;
            acc_idx      = 0;
            ifd_start    = '0;
            entries_todo = '0;
            cur_tag      = '0;
            cur_type     = '0;
            cur_count    = '0;
            width        = '0;
            height       = '0;
            bps          = '0;
            spp          = '0;
            comp         = '0;
            color        = '0;
            n_entries    = '0;
            summary_sent = 1'b0;
        endfunction

        // Shift a byte into the field in the file's byte order
        function void take_byte(logic [7:0] data, int unsigned k);
            if (motorola) begin
                acc = {acc[23:0], data};
            end else begin
                acc = acc | (32'(data) << (8 * (k % 4)));
            end
        endfunction

        // Queue the summary; error summaries carry only status and byte order
        function void close_summary(logic [1:0] status, logic [31:0] next_ptr);
            t_out_item res;
            res = '0;
            res.status     = status;
            res.big_endian = motorola;
            if (status == ST_OK) begin
                res.image_width       = width;
                res.image_height      = height;
                res.bits_per_sample   = bps;
                res.compression_code  = comp;
                res.color_code        = color;
                res.samples_per_pixel = spp;
                res.entry_count       = n_entries;
                res.next_ifd_offset   = next_ptr;
            end
            summary_q.push_back(res);
            predicted++;
            summary_sent = 1'b1;
            phase        = PARSE_DONE;
        endfunction

        // Keep the value of a finished entry if its tag is one of interest
        function void keep_entry();
            logic [31:0] v;
            if (cur_type == TYPE_SHORT) begin
                v = motorola ? {16'd0, acc[31:16]} : {16'd0, acc[15:0]};
            end else begin
                v = acc;
            end
            case (cur_tag)
                TAG_WIDTH:  width  = v;
                TAG_HEIGHT: height = v;
                TAG_BPS:    bps    = (cur_count == 32'd1) ? v[15:0] : 16'd0;
                TAG_SPP:    spp    = v[15:0];
                TAG_COMPRESSION: begin
                    case (v)
                        32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6: comp = v[2:0] - 3'd1;
                        COMP_PACKBITS: comp = 3'd6;
                        default:       comp = COMP_INVALID;
                    endcase
                end
                TAG_PHOTOMETRIC: begin
                    if (v < 32'd7) begin
                        color = v[3:0];
                    end else if (v == 32'd8) begin
                        color = COLOR_CMYK_IN;
                    end else begin
                        color = COLOR_INVALID;
                    end
                end
                default: ;
            endcase
        endfunction

        // Advance the parser by one accepted byte
        function void note_byte(logic [7:0] data, logic last);
            int unsigned k;
            if (!summary_sent) begin
                k = acc_idx;
                if (phase == SEEK_IFD && cursor == ifd_start) begin
                    phase   = IFD_COUNT;
                    acc     = '0;
                    acc_idx = 0;
                    k       = 0;
                end
                case (phase)
                    HDR_MARK: begin
                        if (k == 0) begin
                            acc     = {24'd0, data};
                            acc_idx = 1;
                        end else if (acc == {24'd0, BOM_MOTOROLA} && data == BOM_MOTOROLA) begin
                            motorola = 1'b1;
                            phase    = HDR_VERSION;
                            acc      = '0;
                            acc_idx  = 0;
                        end else if (acc == {24'd0, BOM_INTEL} && data == BOM_INTEL) begin
                            motorola = 1'b0;
                            phase    = HDR_VERSION;
                            acc      = '0;
                            acc_idx  = 0;
                        end else begin
                            motorola = 1'b0;
                            close_summary(ST_BAD_SIG, '0);
                        end
                    end
                    HDR_VERSION: begin
                        if (k == 0) begin
                            acc_idx = 1;
                        end else begin
                            phase   = HDR_OFFSET;
                            acc     = '0;
                            acc_idx = 0;
                        end
                    end
                    HDR_OFFSET: begin
                        take_byte(data, k);
                        if (k < 3) begin
                            acc_idx = k + 1;
                        end else begin
                            ifd_start = acc & 32'((64'd1 << OFFSET_BITS) - 64'd1);
                            acc       = '0;
                            acc_idx   = 0;
                            if (ifd_start < 32'd8) begin
                                close_summary(ST_BEHIND, '0);
                            end else begin
                                phase = SEEK_IFD;
                            end
                        end
                    end
                    IFD_COUNT: begin
                        take_byte(data, k);
                        if (k == 0) begin
                            acc_idx = 1;
                        end else begin
                            entries_todo = acc[15:0];
                            n_entries    = acc[15:0];
                            acc          = '0;
                            acc_idx      = 0;
                            phase        = (acc[15:0] == 16'd0 && entries_todo == 16'd0)
                                           ? IFD_NEXT : IFD_ENTRY;
                        end
                    end
                    IFD_ENTRY: begin
                        // Tag and type are 2-byte fields, count and value 4-byte fields
                        take_byte(data, (k < 4) ? k % 2 : k % 4);
                        if (k == 1) begin
                            cur_tag = acc[15:0];
                            acc     = '0;
                        end else if (k == 3) begin
                            cur_type = acc[15:0];
                            acc      = '0;
                        end else if (k == 7) begin
                            cur_count = acc;
                            acc       = '0;
                        end
                        if (k >= 11) begin
                            keep_entry();
                            acc          = '0;
                            acc_idx      = 0;
                            entries_todo = entries_todo - 16'd1;
                            if (entries_todo == 16'd0) phase = IFD_NEXT;
                        end else begin
                            acc_idx = k + 1;
                        end
                    end
                    IFD_NEXT: begin
                        take_byte(data, k);
                        if (k < 3) begin
                            acc_idx = k + 1;
                        end else begin
                            close_summary(ST_OK, acc);
                        end
                    end
                    default: ;
                endcase
            end
            if (cursor != 32'hFFFF_FFFF) cursor++;
            // The final byte of a file closes it and re-arms the parser
            if (last) begin
                if (!summary_sent) close_summary(ST_TRUNCATED, '0);
                rearm();
            end
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        // Compare a transferred summary with the oldest one owed
        function void check_summary(t_out_item got);
            t_out_item want;
            if (summary_q.size() == 0) begin
                $error("summary with none pending: status %0d", got.status);
                errors++;
            end else begin
                want = summary_q.pop_front();
                checked++;
                if (want.status == ST_OK) ok_seen++;
                compare_field("status", 32'(want.status), 32'(got.status));
                compare_field("big_endian", 32'(want.big_endian), 32'(got.big_endian));
                compare_field("image_width", want.image_width, got.image_width);
                compare_field("image_height", want.image_height, got.image_height);
                compare_field("bits_per_sample", 32'(want.bits_per_sample),
                              32'(got.bits_per_sample));
                compare_field("compression_code", 32'(want.compression_code),
                              32'(got.compression_code));
                compare_field("color_code", 32'(want.color_code), 32'(got.color_code));
                compare_field("samples_per_pixel", 32'(want.samples_per_pixel),
                              32'(got.samples_per_pixel));
                compare_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
                compare_field("next_ifd_offset", want.next_ifd_offset, got.next_ifd_offset);
            end
        endfunction

        function int pending();
            return summary_q.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    tiffp_stream_if #(.t_payload(t_in_item))  in_if ();
    tiffp_stream_if #(.t_payload(t_out_item)) out_if ();

    tiff_ifd_header_parser uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_summary_board sb = new();

    logic [7:0] file_bytes[$];
    int         src_idle_pct  = 26;
    int         sink_idle_pct = 76;
    bit         hold_request  = 1'b0;
    int         bytes_sent    = 0;
    int         files_sent    = 0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Sink side: check each transfer, then pick the next ready
    initial begin
        int hold_left;
        hold_left = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_if.valid && out_if.ready) sb.check_summary(out_if.payload);
            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
            end
        end
    end

    // Watchdog: stop when no transfer happens on either side for too long
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCH_LIMIT) begin
            @(posedge i_clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("no transfer for %0d cycles, %0d summaries pending", WATCH_LIMIT,
                 sb.pending());
        $display("tiff_ifd_header_parser test failed");
        $finish;
    end

    function automatic void put16(logic [15:0] v, bit big);
        if (big) begin
            file_bytes.push_back(v[15:8]);
            file_bytes.push_back(v[7:0]);
        end else begin
            file_bytes.push_back(v[7:0]);
            file_bytes.push_back(v[15:8]);
        end
    endfunction

    function automatic void put32(logic [31:0] v, bit big);
        put16(big ? v[31:16] : v[15:0], big);
        put16(big ? v[15:0] : v[31:16], big);
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom_range(1, 255);
            3:       return $urandom_range(256, 65535);
            default: return $urandom();
        endcase
    endfunction

    // Build one random file; most are well formed, the rest cut or broken
    function automatic void build_file();
        t_file_kind  kind;
        int          draw;
        bit          big;
        logic [31:0] ofs;
        logic [15:0] n_field;
        int          n_written;
        logic [15:0] tag;
        logic [15:0] etype;
        logic [31:0] val;
        int          cut;
        draw = $urandom_range(0, 99);
        if (draw < 62)      kind = FILE_GOOD;
        else if (draw < 78) kind = FILE_CUT;
        else if (draw < 84) kind = FILE_BAD_MARK;
        else if (draw < 88) kind = FILE_BEHIND;
        else if (draw < 91) kind = FILE_FAR;
        else if (draw < 96) kind = FILE_NOISE;
        else                kind = FILE_LONG_COUNT;
        big = 1'($urandom_range(0, 1));
        file_bytes.delete();
        if (kind == FILE_NOISE) begin
            repeat ($urandom_range(1, 24)) file_bytes.push_back(8'($urandom_range(0, 255)));
        end else begin
            // Header: byte order mark, version, first IFD offset
            file_bytes.push_back(big ? BOM_MOTOROLA : BOM_INTEL);
            file_bytes.push_back(big ? BOM_MOTOROLA : BOM_INTEL);
            if (kind == FILE_BAD_MARK) begin
                file_bytes[$urandom_range(0, 1)] = 8'($urandom_range(0, 255));
            end
            put16(16'($urandom_range(0, 65535)), big);
            if (kind == FILE_BEHIND)   ofs = $urandom_range(0, 7);
            else if (kind == FILE_FAR) ofs = $urandom_range(64, 32'hFFFF_FFFF);
            else                       ofs = 8 + $urandom_range(0, 12);
            put32(ofs, big);
            if (ofs >= 8 && ofs < 64) begin
                repeat (ofs - 8) file_bytes.push_back(8'($urandom_range(0, 255)));
            end
            // IFD: entry count, entries, next pointer
            if (kind == FILE_LONG_COUNT) begin
                n_field   = 16'($urandom_range(16, 65535));
                n_written = $urandom_range(0, 3);
            end else begin
                n_field   = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(5, 8))
                                                        : 16'($urandom_range(0, 4));
                n_written = n_field;
            end
            put16(n_field, big);
            repeat (n_written) begin
                case ($urandom_range(0, 7))
                    0:       tag = TAG_WIDTH;
                    1:       tag = TAG_HEIGHT;
                    2:       tag = TAG_BPS;
                    3:       tag = TAG_COMPRESSION;
                    4:       tag = TAG_PHOTOMETRIC;
                    5:       tag = TAG_SPP;
                    default: tag = 16'($urandom_range(0, 65535));
                endcase
                case ($urandom_range(0, 6))
                    0, 1, 2: etype = TYPE_SHORT;
                    3, 4:    etype = TYPE_LONG;
                    default: etype = 16'($urandom_range(0, 65535));
                endcase
                if (tag == TAG_COMPRESSION) begin
                    draw = $urandom_range(0, 9);
                    if (draw < 6)       val = draw + 1;
                    else if (draw == 6) val = COMP_PACKBITS;
                    else if (draw == 7) val = 32'd0;
                    else if (draw == 8) val = 32'd7;
                    else                val = pick_value();
                end else if (tag == TAG_PHOTOMETRIC) begin
                    draw = $urandom_range(0, 10);
                    val  = (draw < 10) ? draw : pick_value();
                end else begin
                    val = pick_value();
                end
                put16(tag, big);
                put16(etype, big);
                put32(($urandom_range(0, 4) != 0) ? 32'd1 : pick_value(), big);
                if (etype == TYPE_SHORT) begin
                    put16(val[15:0], big);
                    put16(16'($urandom_range(0, 65535)), big);
                end else begin
                    put32(val, big);
                end
            end
            put32(($urandom_range(0, 2) == 0) ? 32'd0 : $urandom(), big);
            repeat ($urandom_range(0, 3)) file_bytes.push_back(8'($urandom_range(0, 255)));
            if (kind == FILE_CUT) begin
                cut = $urandom_range(1, file_bytes.size() - 1);
                while (file_bytes.size() > cut) void'(file_bytes.pop_back());
            end
        end
    endfunction

    // Offer one byte, idling first at random, and hold it until transferred
    task automatic push_byte(input logic [7:0] data, input logic last);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.payload <= t_in_item'{data_byte: data, last_byte: last};
        do @(posedge i_clk); while (!in_if.ready);
        sb.note_byte(data, last);
        bytes_sent++;
    endtask

    task automatic send_file();
        foreach (file_bytes[i]) push_byte(file_bytes[i], i == file_bytes.size() - 1);
        files_sent++;
    endtask

    initial begin
        int idle_phase;
        idle_phase = 1;
        i_rst_n       <= 1'b0;
        in_if.valid   <= 1'b0;
        in_if.payload <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: one-byte file, bad mark, offset behind cursor, empty IFD at offset 8
        file_bytes = {8'h49};
        send_file();
        file_bytes = {BOM_MOTOROLA, BOM_INTEL};
        send_file();
        file_bytes = {BOM_MOTOROLA, BOM_MOTOROLA, 8'h00, 8'h2A, 8'h00, 8'h00, 8'h00, 8'h03};
        send_file();
        file_bytes = {BOM_INTEL, BOM_INTEL, 8'h2A, 8'h00, 8'h08, 8'h00, 8'h00, 8'h00,
                      8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_file();

        // Random files, moving through the idle mixes by bytes sent
        while (bytes_sent < ITEM_TARGET) begin
            if (idle_phase == 1 && bytes_sent >= ITEM_TARGET / 3) begin
                idle_phase    = 2;
                src_idle_pct  = 76;
                sink_idle_pct = 26;
            end else if (idle_phase == 2 && bytes_sent >= 2 * ITEM_TARGET / 3) begin
                // No idling; stall the sink for a long stretch so the input backs up
                idle_phase    = 3;
                src_idle_pct  = 0;
                sink_idle_pct = 0;
                hold_request  = 1'b1;
            end
            build_file();
            send_file();
        end
        in_if.valid <= 1'b0;

        // Drain the summaries still owed, then let the pipeline settle
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d bytes in %0d files; checked %0d summaries, %0d with status ok.",
                 bytes_sent, files_sent, sb.checked, sb.ok_seen);
        $display("Files mixed full IFDs in both byte orders with cut, bad-mark and noise ones.");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tiff_ifd_header_parser test passed");
        end else begin
            $display("tiff_ifd_header_parser test failed");
        end
        $finish;
    end

endmodule
